FILE: rtl/rlcg_pkg.sv
// shared types, constants and hue offset tables for the rainbow led colour generator
`default_nettype none

package rlcg_pkg;

	localparam int unsigned LED_TOTAL   = 114;
	localparam int unsigned MATRIX_ROWS = 10;
	localparam int unsigned MATRIX_COLS = 11;

	localparam int unsigned HUE_STEPS = 360;
	localparam int unsigned SECTOR    = 60;
	localparam int unsigned FULL      = 255;

	// hue distance between neighbouring leds of each rainbow
	localparam int unsigned SERP_STEP = HUE_STEPS / (LED_TOTAL - 1);
	localparam int unsigned COL_STEP  = HUE_STEPS / (MATRIX_COLS - 1);
	localparam int unsigned ROW_STEP  = HUE_STEPS / (MATRIX_ROWS - 1);

	localparam int unsigned IDX_W  = 8;
	localparam int unsigned POS_W  = 4;
	localparam int unsigned HUE_W  = 9;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned TAB_N  = 1 << IDX_W;

	typedef logic [HUE_W-1:0] hue_t;
	typedef hue_t ofs_tab_t [TAB_N];

	typedef enum logic [2:0] {
		MODE_PLAIN    = 3'd0,
		MODE_CHANGE   = 3'd1,
		MODE_SERP     = 3'd2,
		MODE_HORZ     = 3'd3,
		MODE_HORZ_MIR = 3'd4,
		MODE_VERT     = 3'd5,
		MODE_VERT_MIR = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		REG_COLOR_MODE  = 3'd0,
		REG_PLAIN_RED   = 3'd1,
		REG_PLAIN_GREEN = 3'd2,
		REG_PLAIN_BLUE  = 3'd3,
		REG_HUE_ROTATE  = 3'd4
	} reg_idx_t;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// ((k + 1) * step) mod 360 for every k, built at elaboration
	function automatic ofs_tab_t make_ofs(input int unsigned step);
		ofs_tab_t t;
		for (int unsigned i = 0; i < TAB_N; i++) begin
			t[i] = hue_t'(((i + 1) * step) % HUE_STEPS);
		end
		return t;
	endfunction

	localparam ofs_tab_t SERP_OFS = make_ofs(SERP_STEP);
	localparam ofs_tab_t COL_OFS  = make_ofs(COL_STEP);
	localparam ofs_tab_t ROW_OFS  = make_ofs(ROW_STEP);

endpackage

`default_nettype wire

FILE: rtl/rainbow_led_color_generator_core.sv
// Rainbow LED colour generator: hue position counter and per-LED HSV colour lookup.
// One item is accepted every clock, except while a query is held as described below. A tick
// item (tuser low) steps the hue position round 0..359 and gives no result; a query item
// (tuser high) gives one colour, loaded first into the input register and then into the
// result register. The hue offset of each LED comes from constant tables, so the
// path between the two registers is one table read, one add with a compare and
// subtract, a sector select and a multiply by 17. While a result waits on m_tready,
// ticks still drain and one query is held in the input register.
`default_nettype none

module rainbow_led_color_generator_core import rlcg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // led_index[7:0], row[11:8], col[15:12], minute_led[16]
	input  wire logic        s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // red[7:0], green[15:8], blue[23:16]
);

	localparam logic [POS_W-1:0] COL_LAST = POS_W'(MATRIX_COLS - 1);
	localparam logic [POS_W-1:0] ROW_LAST = POS_W'(MATRIX_ROWS - 1);
	localparam hue_t HUE_LAST = hue_t'(HUE_STEPS - 1);
	localparam logic [CHAN_W-1:0] CHAN_FULL = CHAN_W'(FULL);

	// configuration
	logic [2:0]        mode_q;
	logic [CHAN_W-1:0] plain_red_q, plain_green_q, plain_blue_q;
	logic              hue_rotate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_PLAIN;
			plain_red_q   <= CHAN_FULL;
			plain_green_q <= CHAN_FULL;
			plain_blue_q  <= CHAN_FULL;
			hue_rotate_q  <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_COLOR_MODE:  mode_q        <= cfg_data[2:0];
				REG_PLAIN_RED:   plain_red_q   <= cfg_data;
				REG_PLAIN_GREEN: plain_green_q <= cfg_data;
				REG_PLAIN_BLUE:  plain_blue_q  <= cfg_data;
				REG_HUE_ROTATE:  hue_rotate_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	logic             valid_s1;
	logic             cmd_s1;
	logic [IDX_W-1:0] led_index_s1;
	logic [POS_W-1:0] row_s1, col_s1;
	logic             minute_s1;
	logic             out_free;
	logic             go_s1;
	logic             take_in;

	assign out_free = !m_tvalid || m_tready;
	assign go_s1    = valid_s1 && ((cmd_s1 == CMD_TICK) || out_free);
	assign s_tready = !valid_s1 || go_s1;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1       <= s_tuser;
			led_index_s1 <= s_tdata[7:0];
			row_s1       <= s_tdata[11:8];
			col_s1       <= s_tdata[15:12];
			minute_s1    <= s_tdata[16];
		end
	end

	// hue position, stepped when a tick leaves the input register
	hue_t hue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q <= '0;
		end else if (go_s1 && (cmd_s1 == CMD_TICK)) begin
			hue_q <= (hue_q == HUE_LAST) ? '0 : hue_q + hue_t'(1);
		end
	end

	// hue of the queried led
	logic [POS_W-1:0] col_sat, row_sat, col_k, row_k;
	hue_t             start, ofs, hue;
	logic [HUE_W:0]   hue_sum;

	always_comb begin
		col_sat = (col_s1 > COL_LAST) ? COL_LAST : col_s1;
		row_sat = (row_s1 > ROW_LAST) ? ROW_LAST : row_s1;
		col_k   = (mode_q == MODE_HORZ_MIR) ? COL_LAST - col_sat : col_sat;
		row_k   = (mode_q == MODE_VERT_MIR) ? ROW_LAST - row_sat : row_sat;
		start   = hue_rotate_q ? hue_q : '0;
		case (mode_q)
			MODE_SERP:                 ofs = SERP_OFS[led_index_s1];
			MODE_HORZ, MODE_HORZ_MIR:  ofs = COL_OFS[IDX_W'(col_k)];
			MODE_VERT, MODE_VERT_MIR:  ofs = ROW_OFS[IDX_W'(row_k)];
			default:                   ofs = '0;
		endcase
		hue_sum = {1'b0, start} + {1'b0, ofs};
		if (mode_q == MODE_CHANGE) begin
			hue = hue_q;
		end else if (hue_sum >= (HUE_W + 1)'(HUE_STEPS)) begin
			hue = hue_t'(hue_sum - (HUE_W + 1)'(HUE_STEPS));
		end else begin
			hue = hue_t'(hue_sum);
		end
	end

	// full saturation hsv: 255 / 60 is exactly 17 / 4
	logic [2:0]        sector;
	logic [5:0]        frac;
	logic [9:0]        up_w, down_w;
	logic [CHAN_W-1:0] up, down;
	logic [CHAN_W-1:0] hr, hg, hb;

	always_comb begin
		if (hue >= hue_t'(5 * SECTOR)) begin
			sector = 3'd5; frac = 6'(hue - hue_t'(5 * SECTOR));
		end else if (hue >= hue_t'(4 * SECTOR)) begin
			sector = 3'd4; frac = 6'(hue - hue_t'(4 * SECTOR));
		end else if (hue >= hue_t'(3 * SECTOR)) begin
			sector = 3'd3; frac = 6'(hue - hue_t'(3 * SECTOR));
		end else if (hue >= hue_t'(2 * SECTOR)) begin
			sector = 3'd2; frac = 6'(hue - hue_t'(2 * SECTOR));
		end else if (hue >= hue_t'(SECTOR)) begin
			sector = 3'd1; frac = 6'(hue - hue_t'(SECTOR));
		end else begin
			sector = 3'd0; frac = 6'(hue);
		end
		up_w   = 10'(frac) * 10'd17;
		down_w = (10'(SECTOR) - 10'(frac)) * 10'd17;
		up     = up_w[9:2];
		down   = down_w[9:2];
		case (sector)
			3'd0:    begin hr = CHAN_FULL; hg = up;        hb = '0;        end
			3'd1:    begin hr = down;      hg = CHAN_FULL; hb = '0;        end
			3'd2:    begin hr = '0;        hg = CHAN_FULL; hb = up;        end
			3'd3:    begin hr = '0;        hg = down;      hb = CHAN_FULL; end
			3'd4:    begin hr = up;        hg = '0;        hb = CHAN_FULL; end
			default: begin hr = CHAN_FULL; hg = '0;        hb = down;      end
		endcase
	end

	// final colour per mode
	logic [CHAN_W-1:0] red_c, green_c, blue_c;

	always_comb begin
		case (mode_q)
			MODE_CHANGE, MODE_SERP: begin
				red_c = hr; green_c = hg; blue_c = hb;
			end
			MODE_HORZ, MODE_HORZ_MIR, MODE_VERT, MODE_VERT_MIR: begin
				if (minute_s1) begin
					red_c = CHAN_FULL; green_c = CHAN_FULL; blue_c = CHAN_FULL;
				end else begin
					red_c = hr; green_c = hg; blue_c = hb;
				end
			end
			default: begin
				red_c = plain_red_q; green_c = plain_green_q; blue_c = plain_blue_q;
			end
		endcase
	end

	// result register
	logic load_out;
	assign load_out = go_s1 && (cmd_s1 == CMD_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= {blue_c, green_c, red_c};
		end
	end

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hue_q <= HUE_LAST)
		else $error("hue position out of range");

	a_hue_step: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && cmd_s1 == CMD_TICK) |=>
		(hue_q == $past(hue_q) + hue_t'(1) || (hue_q == '0 && $past(hue_q) == HUE_LAST)))
		else $error("hue position did not step correctly");

	a_hue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(go_s1 && cmd_s1 == CMD_TICK) |=> $stable(hue_q))
		else $error("hue position changed without a tick");

	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1 == CMD_QUERY && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while a query is held");

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && cmd_s1 == CMD_QUERY))
		else $error("result without a query");
`endif

endmodule

`default_nettype wire

FILE: dv/tb.sv
// self-checking bench for the rainbow led colour generator core
`timescale 1ns / 1ps

module tb import rlcg_pkg::*;;

	localparam int unsigned ITEMS = 1450;
	localparam logic [2:0] MODE_UNDEF = 3'd7;

	typedef struct {
		logic        cmd;
		logic [23:0] data;
	} bus_item_t;

	// red in the low byte, as on m_tdata
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} colour_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // led_index[7:0], row[11:8], col[15:12], minute_led[16]
	logic        s_tuser;   // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // red[7:0], green[15:8], blue[23:16]

	bus_item_t   pending_items[$];
	colour_t     colours_due[$];
	int          errors = 0;
	int unsigned issued = 0;

	// shadow of the block's registers and hue counter
	logic [2:0]  cfg_mode = MODE_PLAIN;
	logic [7:0]  cfg_red = 8'hff;
	logic [7:0]  cfg_green = 8'hff;
	logic [7:0]  cfg_blue = 8'hff;
	logic        cfg_rotate = 1'b1;
	int unsigned hue_pos = 0;

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;

	rainbow_led_color_generator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// full saturation and value, so each sector ramps one channel
	function automatic colour_t hue_colour(input int unsigned hue);
		int unsigned f, up, down;
		colour_t c;
		f = hue % SECTOR;
		up = (FULL * f) / SECTOR;
		down = (FULL * (SECTOR - f)) / SECTOR;
		case (hue / SECTOR)
			0: begin
				c.red = 8'(FULL); c.green = 8'(up); c.blue = 8'd0;
			end
			1: begin
				c.red = 8'(down); c.green = 8'(FULL); c.blue = 8'd0;
			end
			2: begin
				c.red = 8'd0; c.green = 8'(FULL); c.blue = 8'(up);
			end
			3: begin
				c.red = 8'd0; c.green = 8'(down); c.blue = 8'(FULL);
			end
			4: begin
				c.red = 8'(up); c.green = 8'd0; c.blue = 8'(FULL);
			end
			default: begin
				c.red = 8'(FULL); c.green = 8'd0; c.blue = 8'(down);
			end
		endcase
		return c;
	endfunction

	function automatic int unsigned ring_hue(input int unsigned start, input int unsigned k,
			input int unsigned count);
		return (start + (k + 1) * (HUE_STEPS / (count - 1))) % HUE_STEPS;
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hff;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	task automatic push_item(input logic cmd, input logic [7:0] led, input logic [3:0] row,
			input logic [3:0] col, input logic minute);
		bus_item_t it;
		it.cmd = cmd;
		it.data = {7'd0, minute, col, row, led};
		pending_items.push_back(it);
		issued++;
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_items.size() != 0 || s_tvalid || colours_due.size() != 0);
		// ticks leave nothing in the queue, so give the pipe time to drain
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic apply_setting(input logic [2:0] mode, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic rot);
		wait_idle();
		write_reg(REG_COLOR_MODE, {5'd0, mode});
		write_reg(REG_PLAIN_RED, r);
		write_reg(REG_PLAIN_GREEN, g);
		write_reg(REG_PLAIN_BLUE, b);
		write_reg(REG_HUE_ROTATE, {7'd0, rot});
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_mode = mode;
		cfg_red = r;
		cfg_green = g;
		cfg_blue = b;
		cfg_rotate = rot;
		@(negedge clk);
	endtask

	// sender: bursts of items with random gaps between them
	always @(posedge clk) begin
		bus_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= it.cmd;
				s_tdata <= it.data;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: short stalls now and then, with calm stretches of no stall
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (calm_left > 0) begin
				calm_left <= calm_left - 1;
			end else if ($urandom_range(0, 99) < 3) begin
				calm_left <= $urandom_range(50, 300);
			end else if ($urandom_range(0, 99) < 30) begin
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
					: $urandom_range(1, 6);
			end
		end
	end

	// checks results first, then predicts the colour of a newly accepted query
	always @(posedge clk) begin
		colour_t want, got;
		int unsigned start, row_s, col_s;
		string chan_name [3];
		chan_name = '{"red", "green", "blue"};
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (colours_due.size() == 0) begin
				$display("%0t: unexpected colour, expected none, got %06h", $time, m_tdata);
				errors++;
			end else begin
				want = colours_due.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (got[8*i +: 8] !== want[8*i +: 8]) begin
						$display("%0t: %s expected %0d got %0d", $time, chan_name[i],
							want[8*i +: 8], got[8*i +: 8]);
						errors++;
					end
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			if (s_tuser == CMD_TICK) begin
				hue_pos = (hue_pos + 1 >= HUE_STEPS) ? 0 : hue_pos + 1;
			end else begin
				start = cfg_rotate ? hue_pos : 0;
				row_s = s_tdata[11:8];
				col_s = s_tdata[15:12];
				if (row_s > MATRIX_ROWS - 1) row_s = MATRIX_ROWS - 1;
				if (col_s > MATRIX_COLS - 1) col_s = MATRIX_COLS - 1;
				case (cfg_mode)
					MODE_CHANGE: begin
						want = hue_colour(hue_pos);
					end
					MODE_SERP: begin
						want = hue_colour(ring_hue(start, s_tdata[7:0], LED_TOTAL));
					end
					MODE_HORZ, MODE_HORZ_MIR, MODE_VERT, MODE_VERT_MIR: begin
						if (s_tdata[16]) begin
							want = {8'hff, 8'hff, 8'hff};
						end else if (cfg_mode == MODE_HORZ) begin
							want = hue_colour(ring_hue(start, col_s, MATRIX_COLS));
						end else if (cfg_mode == MODE_HORZ_MIR) begin
							want = hue_colour(ring_hue(start, MATRIX_COLS - 1 - col_s,
								MATRIX_COLS));
						end else if (cfg_mode == MODE_VERT) begin
							want = hue_colour(ring_hue(start, row_s, MATRIX_ROWS));
						end else begin
							want = hue_colour(ring_hue(start, MATRIX_ROWS - 1 - row_s,
								MATRIX_ROWS));
						end
					end
					default: begin
						// undefined mode falls back to plain
						want = {cfg_blue, cfg_green, cfg_red};
					end
				endcase
				colours_due.push_back(want);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [2:0] mode;
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_COLOR_MODE;
		cfg_data <= 8'd0;
		s_tvalid <= 1'b0;
		s_tdata <= 24'd0;
		s_tuser <= CMD_TICK;
		m_tready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: plain white with rotation on
		push_item(CMD_TICK, 8'd0, 4'd0, 4'd0, 1'b0);
		push_item(CMD_QUERY, 8'd255, 4'd15, 4'd15, 1'b1);
		push_item(CMD_QUERY, 8'd0, 4'd0, 4'd0, 1'b0);

		// every mode, the undefined one too, at both ends of the position fields
		for (int m = 0; m < 8; m++) begin
			mode = 3'(m);
			apply_setting(mode, 8'(m * 37), 8'hff - 8'(m * 37), 8'(m * 91), mode[0]);
			push_item(CMD_QUERY, 8'd0, 4'd0, 4'd0, 1'b0);
			push_item(CMD_QUERY, 8'd255, 4'd15, 4'd15, mode[0]);
			push_item(CMD_TICK, 8'd255, 4'd15, 4'd15, 1'b1);
		end

		// extremes of the plain colour and rotation before the random phases
		apply_setting(MODE_PLAIN, 8'h00, 8'h00, 8'h00, 1'b0);
		push_item(CMD_QUERY, 8'($urandom_range(0, 255)), 4'd5, 4'd5, 1'b1);
		apply_setting(MODE_UNDEF, 8'hff, 8'hff, 8'hff, 1'b1);
		push_item(CMD_QUERY, 8'd114, 4'd10, 4'd11, 1'b0);

		while (issued < ITEMS) begin
			apply_setting(3'($urandom_range(0, 7)), pick_level(), pick_level(), pick_level(),
				1'($urandom_range(0, 1)));
			repeat ($urandom_range(40, 140)) begin
				push_item(($urandom_range(0, 99) < 40) ? CMD_TICK : CMD_QUERY,
					8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/rlcg_pkg.sv
rtl/rainbow_led_color_generator_core.sv
dv/tb.sv
